### hw/rtl/dd_pkg.sv
// shared types, constants and calendar tables for the date difference block
`default_nettype none

package dd_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned COUNT_W = 22;
	localparam int unsigned IN_W    = 48;
	localparam int unsigned OUT_W   = 24;

	localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for any 14-bit x
	localparam int unsigned RECIP_W     = 13;
	localparam int unsigned RECIP_SHIFT = 19;
	localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
	localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_Y,
		ST_MUL_P,
		ST_CHECK,
		ST_BASE,
		ST_DAYNUM,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MUL_Y,
		OP_MUL_P,
		OP_CHECK,
		OP_BASE,
		OP_DAYNUM,
		OP_OUT
	} op_t;

	typedef struct packed {
		logic load;
		logic sel_end;
		op_t  op;
	} cmd_t;

	// last member sits in the low bits, so start_year lands at tdata[13:0]
	typedef struct packed {
		logic               include_end;
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [YEAR_W-1:0]  end_year;
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
	} item_t;

	// days in a month, zero for a month code that means nothing
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		len = '0;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = '0;
		endcase
		return len;
	endfunction

	// days before the first of a month in a common year
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		n = '0;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/dd_ctrl.sv
// controller that sequences the day number conversion and the output handshake
`default_nettype none

module dd_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire               m_tready,
	output dd_pkg::cmd_t      cmd
);

	dd_pkg::state_t state_q, state_d;
	logic end_q, end_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dd_pkg::ST_IDLE;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			end_q       <= end_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		end_d       = end_q;
		out_valid_d = out_valid_q;
		s_tready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.sel_end = end_q;
		cmd.op      = dd_pkg::OP_NONE;

		// result taken by the sink
		if (out_valid_q && m_tready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			dd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					end_d    = 1'b0;
					state_d  = dd_pkg::ST_MUL_Y;
				end
			end
			dd_pkg::ST_MUL_Y: begin
				cmd.op  = dd_pkg::OP_MUL_Y;
				state_d = dd_pkg::ST_MUL_P;
			end
			dd_pkg::ST_MUL_P: begin
				cmd.op  = dd_pkg::OP_MUL_P;
				state_d = dd_pkg::ST_CHECK;
			end
			dd_pkg::ST_CHECK: begin
				cmd.op  = dd_pkg::OP_CHECK;
				state_d = dd_pkg::ST_BASE;
			end
			dd_pkg::ST_BASE: begin
				cmd.op  = dd_pkg::OP_BASE;
				state_d = dd_pkg::ST_DAYNUM;
			end
			dd_pkg::ST_DAYNUM: begin
				cmd.op = dd_pkg::OP_DAYNUM;
				if (end_q) begin
					state_d = dd_pkg::ST_FINISH;
				end else begin
					end_d   = 1'b1;
					state_d = dd_pkg::ST_MUL_Y;
				end
			end
			dd_pkg::ST_FINISH: begin
				// output register free or being emptied this cycle
				if (!out_valid_q || m_tready) begin
					cmd.op      = dd_pkg::OP_OUT;
					out_valid_d = 1'b1;
					state_d     = dd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dd_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/dd_datapath.sv
// datapath: date checks, day numbers through a shared reciprocal multiplier, difference
`default_nettype none

module dd_datapath (
	input  wire                          clk,
	input  wire  [dd_pkg::IN_W-1:0]      s_tdata,
	input  dd_pkg::cmd_t                 cmd,
	output logic [dd_pkg::OUT_W-1:0]     m_tdata
);

	dd_pkg::item_t in_q;

	logic [dd_pkg::PROD_W-1:0]  mul_q;
	logic [dd_pkg::QUOT_W-1:0]  qy_q;
	logic [dd_pkg::QUOT_W-1:0]  qp_q;
	logic                       leap_q;
	logic                       ok_q;
	logic [dd_pkg::COUNT_W-1:0] base_q;
	logic [dd_pkg::COUNT_W-1:0] a_q;
	logic [dd_pkg::COUNT_W-1:0] b_q;
	logic [dd_pkg::COUNT_W-1:0] count_q;
	logic                       bad_q;

	logic [dd_pkg::YEAR_W-1:0]  y;
	logic [dd_pkg::YEAR_W-1:0]  p;
	logic [dd_pkg::MONTH_W-1:0] m;
	logic [dd_pkg::DAY_W-1:0]   d;
	logic [dd_pkg::YEAR_W-1:0]  mul_opnd;
	logic [dd_pkg::PROD_W-1:0]  prod;
	logic [dd_pkg::QUOT_W-1:0]  quot;
	logic [dd_pkg::YEAR_W:0]    qy_x100;
	logic                       div100;
	logic                       leap;
	logic                       year_ok;
	logic                       month_ok;
	logic                       day_ok;
	logic [dd_pkg::YEAR_W+8:0]  base;
	logic [dd_pkg::COUNT_W-1:0] daynum;
	logic [dd_pkg::COUNT_W-1:0] diff;
	logic [dd_pkg::COUNT_W-1:0] count;

	// fields of the date in work
	always_comb begin
		if (cmd.sel_end) begin
			y = in_q.end_year;
			m = in_q.end_month;
			d = in_q.end_day;
		end else begin
			y = in_q.start_year;
			m = in_q.start_month;
			d = in_q.start_day;
		end
	end

	assign p        = y - dd_pkg::YEAR_W'(1);
	assign mul_opnd = (cmd.op == dd_pkg::OP_MUL_P) ? p : y;
	assign prod     = dd_pkg::PROD_W'(mul_opnd) * dd_pkg::PROD_W'(dd_pkg::RECIP_100);
	assign quot     = mul_q[dd_pkg::PROD_W-1:dd_pkg::RECIP_SHIFT];

	// leap: divisible by 4, and by 400 when divisible by 100
	assign qy_x100 = (dd_pkg::YEAR_W+1)'(qy_q) * (dd_pkg::YEAR_W+1)'(100);
	assign div100  = (qy_x100 == {1'b0, y});
	assign leap    = (y[1:0] == 2'b00) && (!div100 || (qy_q[1:0] == 2'b00));

	assign year_ok  = (y >= dd_pkg::YEAR_MIN) && (y <= dd_pkg::YEAR_MAX);
	assign month_ok = (m >= dd_pkg::MONTH_JAN) && (m <= dd_pkg::MONTH_DEC);
	assign day_ok   = (d != '0) && (d <= dd_pkg::month_len(m, leap));

	// p*365 + p/4 - p/100 + p/400
	assign base = (dd_pkg::YEAR_W+9)'(p) * (dd_pkg::YEAR_W+9)'(365)
		+ (dd_pkg::YEAR_W+9)'(p[dd_pkg::YEAR_W-1:2])
		- (dd_pkg::YEAR_W+9)'(qp_q)
		+ (dd_pkg::YEAR_W+9)'(qp_q[dd_pkg::QUOT_W-1:2]);

	assign daynum = base_q
		+ dd_pkg::COUNT_W'(dd_pkg::days_before(m))
		+ dd_pkg::COUNT_W'((m > dd_pkg::MONTH_FEB) && leap_q)
		+ dd_pkg::COUNT_W'(d)
		- dd_pkg::COUNT_W'(1);

	assign diff  = (a_q < b_q) ? (b_q - a_q) : '0;
	assign count = ok_q ? (diff + dd_pkg::COUNT_W'(in_q.include_end)) : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= dd_pkg::item_t'(s_tdata[$bits(dd_pkg::item_t)-1:0]);
			ok_q <= 1'b1;
		end
		unique case (cmd.op)
			dd_pkg::OP_MUL_Y: begin
				mul_q <= prod;
			end
			dd_pkg::OP_MUL_P: begin
				qy_q  <= quot;
				mul_q <= prod;
			end
			dd_pkg::OP_CHECK: begin
				qp_q   <= quot;
				leap_q <= leap;
				ok_q   <= ok_q && year_ok && month_ok && day_ok;
			end
			dd_pkg::OP_BASE: begin
				base_q <= base[dd_pkg::COUNT_W-1:0];
			end
			dd_pkg::OP_DAYNUM: begin
				if (cmd.sel_end) begin
					b_q <= daynum;
				end else begin
					a_q <= daynum;
				end
			end
			dd_pkg::OP_OUT: begin
				count_q <= count;
				bad_q   <= !ok_q;
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = {{(dd_pkg::OUT_W-dd_pkg::COUNT_W-1){1'b0}}, bad_q, count_q};

endmodule

`default_nettype wire

### hw/rtl/date_difference_in_days.sv
// days between two gregorian dates: each date is checked and turned into a day number
// the result is registered once the end date is converted and the output register is free
// one item at a time: a new input is taken only once the last result is in the output register,
// as two passes of the shared reciprocal multiplier and adder chain convert start and end dates in turn
// reset clears the controller and the output valid; data registers are not reset
`default_nettype none

module date_difference_in_days (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	// start_year[13:0], start_month[17:14], start_day[22:18], end_year[36:23],
	// end_month[40:37], end_day[45:41], include_end[46], zero[47]
	input  wire  [dd_pkg::IN_W-1:0]   s_tdata,
	output logic                      m_tvalid,
	input  wire                       m_tready,
	// day_count[21:0], bad_date[22], zero[23]
	output logic [dd_pkg::OUT_W-1:0]  m_tdata
);

	dd_pkg::cmd_t cmd;

	dd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	dd_datapath u_datapath (
		.clk     (clk),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire
